// ----- design/cis_pkg.sv -----
`default_nettype none
package cis_pkg;
	localparam int DEF_MAX_INTERVALS = 64;
	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_INVERT = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_READ = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_INDEX = 2'd3;
	typedef struct packed {
		logic [CP_W-1:0] first;
		logic [CP_W-1:0] last;
	} span_t;
endpackage
`default_nettype wire

// ----- design/codepoint_interval_set.sv -----
// codepoint_interval_set: a set of Unicode codepoints held as a sorted table of
// disjoint, non-adjacent inclusive intervals in a two-bank synchronous memory.
// Input channel: in_valid / in_stall with action, range_low, range_high,
// entry_index. One result per item on out_valid / out_stall carrying status,
// interval_total, entry_first, entry_last.
// One item at a time: a transfer is taken only when the block is idle and the
// result register is empty.
// Add and invert stream the live bank, reading each entry in turn, into the
// other bank, merging or complementing on the way, then flip the bank select.
// A result that would need more than MAX_INTERVALS entries leaves the flip
// undone, so the set is untouched and status reads full.
// States from input transfer to out_valid:
//   clear, reversed range, range above the codepoint space, bad index:
//   straight to S_DONE; read: S_RDW, S_RDD, S_DONE
//   add or invert: S_RD, S_WR per entry, plus S_WR2 when an add writes the new
//   or merged interval ahead of an existing entry, then S_TAIL, S_FIN, S_DONE
// The next input transfer comes at the earliest in the cycle after the
// result transfer.
// Reset clears the count, bank select, control and result register; memory
// contents stay undefined as only entries below the count are read.
// While out_stall is high the result holds and no new input is taken.
`default_nettype none
module codepoint_interval_set #(
	parameter int MAX_INTERVALS = cis_pkg::DEF_MAX_INTERVALS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               action,
	input  wire logic [20:0]              range_low,
	input  wire logic [20:0]              range_high,
	input  wire logic [5:0]               entry_index,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [1:0]                    status,
	output logic [6:0]                    interval_total,
	output logic [20:0]                   entry_first,
	output logic [20:0]                   entry_last
);
	import cis_pkg::*;

	localparam int AW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int NW = CW + 1;
	localparam logic [NW-1:0] NMAX = NW'(MAX_INTERVALS);

	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_WR = 4'd2,
		S_WR2 = 4'd3, S_TAIL = 4'd4, S_FIN = 4'd5, S_RDW = 4'd6,
		S_RDD = 4'd7, S_DONE = 4'd8;

	span_t mem_q [2][MAX_INTERVALS];
	logic bank_q;
	span_t rd_s1;

	logic [3:0] st_q;
	logic [CW-1:0] cnt_q, k_q;
	logic [NW-1:0] n_q;          // entries emitted for the spare bank; writes stop at MAX_INTERVALS
	logic [1:0] act_q;
	logic [CP_W-1:0] lo_q, hi_q, mf_q, ml_q;
	logic [CP_W:0] hip1_q, from_q;
	logic [5:0] idx_q;
	logic placed_q, hold_q;      // new range placed / merged interval still open

	logic rd_en, wr_en, emit, below, touch, gap, dbl, last_e;
	logic [AW-1:0] rd_a;
	logic [CP_W-1:0] hi_clip;
	span_t emit_d;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[~bank_q][n_q[AW-1:0]] <= emit_d;
		if (rd_en) rd_s1 <= mem_q[bank_q][rd_a];
	end

	assign in_stall = (st_q != S_IDLE) || out_valid;
	assign hi_clip = (range_high > CP_MAX) ? CP_MAX : range_high;

	// entry read back against the range or the running complement edge
	assign below = ({1'b0, rd_s1.last} + 1'b1) < {1'b0, lo_q};
	assign touch = {1'b0, rd_s1.first} <= hip1_q;
	assign gap = {1'b0, rd_s1.first} > from_q;
	assign dbl = (st_q == S_WR) && (act_q == ACT_ADD) && !touch
		&& (placed_q ? hold_q : !below);
	assign last_e = (k_q == cnt_q - CW'(1));
	assign wr_en = emit && (n_q < NMAX);

	always_comb begin
		emit = 1'b0; emit_d = rd_s1; rd_en = 1'b0; rd_a = k_q[AW-1:0];
		unique case (st_q)
			S_RD: rd_en = 1'b1;
			S_RDW: begin rd_en = 1'b1; rd_a = AW'(idx_q); end
			S_WR: begin
				if (act_q == ACT_INVERT) begin
					emit = gap;
					emit_d = {from_q[CP_W-1:0], rd_s1.first - CP_W'(1)};
				end else if (!placed_q) begin
					emit = below || !touch;
					emit_d = below ? rd_s1 : {lo_q, hi_q};
				end else begin
					emit = !hold_q || !touch;
					emit_d = hold_q ? {mf_q, ml_q} : rd_s1;
				end
			end
			// entry held in rd_s1 after the new or merged interval went first
			S_WR2: emit = 1'b1;
			S_TAIL: begin
				if (act_q == ACT_INVERT) begin
					emit = (from_q <= {1'b0, CP_MAX});
					emit_d = {from_q[CP_W-1:0], CP_MAX};
				end else begin
					emit = !placed_q || hold_q;
					emit_d = placed_q ? {mf_q, ml_q} : {lo_q, hi_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; cnt_q <= '0; bank_q <= 1'b0; out_valid <= 1'b0;
			k_q <= '0; n_q <= '0; act_q <= ACT_ADD; idx_q <= '0;
			lo_q <= '0; hi_q <= '0; mf_q <= '0; ml_q <= '0;
			hip1_q <= '0; from_q <= '0; placed_q <= 1'b0; hold_q <= 1'b0;
			status <= ST_OK; interval_total <= '0;
			entry_first <= '0; entry_last <= '0;
		end else begin
			if (st_q == S_DONE) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (emit) n_q <= n_q + 1'b1;
			unique case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					act_q <= action; idx_q <= entry_index; k_q <= '0; n_q <= '0;
					lo_q <= range_low; hi_q <= hi_clip;
					hip1_q <= {1'b0, hi_clip} + 1'b1;
					placed_q <= 1'b0; hold_q <= 1'b0; from_q <= '0;
					entry_first <= '0; entry_last <= '0; status <= ST_OK;
					unique case (action)
						ACT_ADD: begin
							if (range_low > range_high) begin
								status <= ST_ORDER; st_q <= S_DONE;
							end else if (range_low > CP_MAX) st_q <= S_DONE;
							else st_q <= (cnt_q == '0) ? S_TAIL : S_RD;
						end
						ACT_INVERT: st_q <= (cnt_q == '0) ? S_TAIL : S_RD;
						ACT_CLEAR: begin cnt_q <= '0; st_q <= S_DONE; end
						ACT_READ: begin
							if (32'(entry_index) < 32'(cnt_q)) st_q <= S_RDW;
							else begin status <= ST_INDEX; st_q <= S_DONE; end
						end
					endcase
				end
				S_RD: st_q <= S_WR;
				S_WR: begin
					if (act_q == ACT_INVERT) begin
						from_q <= {1'b0, rd_s1.last} + 1'b1;
					end else if (!placed_q) begin
						if (!below) placed_q <= 1'b1;
						if (!below && touch) begin
							hold_q <= 1'b1;
							mf_q <= (rd_s1.first < lo_q) ? rd_s1.first : lo_q;
							ml_q <= (rd_s1.last > hi_q) ? rd_s1.last : hi_q;
						end
					end else if (hold_q) begin
						if (!touch) hold_q <= 1'b0;
						else if (rd_s1.last > ml_q) ml_q <= rd_s1.last;
					end
					if (dbl) st_q <= S_WR2;
					else if (last_e) st_q <= S_TAIL;
					else begin k_q <= k_q + 1'b1; st_q <= S_RD; end
				end
				S_WR2: begin
					if (last_e) st_q <= S_TAIL;
					else begin k_q <= k_q + 1'b1; st_q <= S_RD; end
				end
				S_TAIL: st_q <= S_FIN;
				// too many entries: keep the live bank, report full; else flip the bank
				S_FIN: begin
					if (n_q > NMAX) status <= ST_FULL;
					else begin bank_q <= ~bank_q; cnt_q <= n_q[CW-1:0]; end
					st_q <= S_DONE;
				end
				S_RDW: st_q <= S_RDD;
				S_RDD: begin
					entry_first <= rd_s1.first; entry_last <= rd_s1.last; st_q <= S_DONE;
				end
				S_DONE: begin interval_total <= 7'(cnt_q); st_q <= S_IDLE; end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
